### rtl/core/driver_vigilance_timer_macros.svh
// ----------------------------------------------------------------------------
// Driver vigilance timer assertion macros
// Shared concurrent assertion forms for the checker of the vigilance timer.
// ----------------------------------------------------------------------------
`ifndef DRIVER_VIGILANCE_TIMER_MACROS_SVH
`define DRIVER_VIGILANCE_TIMER_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define DVT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dvt assertion failed");

// Next-cycle implication, disabled while rst is high.
`define DVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dvt assertion failed");

`endif

### rtl/core/dvt_pkg.sv
// ----------------------------------------------------------------------------
// dvt_pkg
// Types, field widths and constants of the driver vigilance timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvt_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int MS_W      = 16;
   localparam int SPEED_W   = 12;
   localparam int DT_W      = 7;
   localparam int STAGE_W   = 3;
   localparam int TIMER_W   = 18;

   localparam logic [TIMER_W-1:0] TIMER_MAX   = '1;
   localparam logic [TIMER_W-1:0] TIMER_RESET = 18'd3000;

   localparam logic [MS_W-1:0]    CYCLE_MS_RESET         = 16'd15000;
   localparam logic [MS_W-1:0]    VISUAL_MS_RESET        = 16'd4000;
   localparam logic [MS_W-1:0]    AUDIBLE_MS_RESET       = 16'd4000;
   localparam logic [SPEED_W-1:0] ACTIVE_SPEED_RESET     = 12'd10;
   localparam logic [SPEED_W-1:0] STANDSTILL_SPEED_RESET = 12'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_MS         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VISUAL_MS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUDIBLE_MS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_SPEED     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STANDSTILL_SPEED = 3'd4;

   typedef enum logic [STAGE_W-1:0] {
      STAGE_INACTIVE = 3'd0,
      STAGE_ARMED    = 3'd1,
      STAGE_VISUAL   = 3'd2,
      STAGE_AUDIBLE  = 3'd3,
      STAGE_PENALTY  = 3'd4
   } stage_type;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_ACK  = 1'b1
   } req_kind_type;

endpackage

### rtl/core/driver_vigilance_timer.sv
// ----------------------------------------------------------------------------
// driver_vigilance_timer
// Dead-man supervision timer with armed, visual, audible and penalty stages.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock on the req_ stream, unless the
// result register is stalled by rsp_tready, and returns exactly one result
// transaction on the rsp_ stream for each of them, in order. A request is
// either a time tick (tuser low) carrying elapsed milliseconds and the
// train speed, or a pedal acknowledge (tuser high) carrying the speed. Each
// request passes through an input register and then the result register;
// the state update of one request completes in the same cycle its result
// is registered, which is what lets the next request follow directly
// behind it. When the result register is stalled by rsp_tready, the input
// register still takes one more transaction before req_tready falls.
// Configuration writes on the csr_ port are always accepted and should
// only be issued while no request is in flight.
`timescale 1ns / 1ps

module driver_vigilance_timer (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: [6:0] elapsed_ms, [18:7] speed, [23:19] zero.
   input  logic [dvt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: [0] req_type (0 time tick, 1 pedal acknowledge).
   input  logic                              req_tuser,
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: [2:0] stage, [18:3] countdown_ms, [19] penalty_brake, [23:20] zero.
   output logic [dvt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dvt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dvt_pkg::CSR_DATA_W-1:0]    csr_data
);
   import dvt_pkg::*;

   // Input register stage.
   logic                 in_vld_ff;
   req_kind_type         in_kind_ff;
   logic [DT_W-1:0]      in_dt_ff;
   logic [SPEED_W-1:0]   in_spd_ff;

   // Configuration registers.
   logic [MS_W-1:0]      cycle_ms_ff;
   logic [MS_W-1:0]      visual_ms_ff;
   logic [MS_W-1:0]      audible_ms_ff;
   logic [SPEED_W-1:0]   active_speed_ff;
   logic [SPEED_W-1:0]   standstill_speed_ff;

   // Supervision state and its next values.
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic                 latch_ff, latch_in;
   stage_type            stage_ff, stage_in;
   logic [MS_W-1:0]      countdown_ff, countdown_in;

   // Result register.
   logic                    rsp_vld_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                 load_in;
   logic                 advance;
   logic [TIMER_W:0]     timer_sum;
   logic [TIMER_W-1:0]   timer_add;
   logic [TIMER_W-1:0]   bound1, bound2, bound3;
   logic [TIMER_W-1:0]   left1, left2, left3;

   // The input register moves on whenever the result register is empty or
   // is being drained in this cycle.
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign load_in    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (load_in) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_kind_ff <= req_kind_type'(req_tuser);
         in_dt_ff   <= req_tdata[DT_W-1:0];
         in_spd_ff  <= req_tdata[DT_W+SPEED_W-1:DT_W];
      end
   end

   // Configuration writes; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ms_ff         <= CYCLE_MS_RESET;
         visual_ms_ff        <= VISUAL_MS_RESET;
         audible_ms_ff       <= AUDIBLE_MS_RESET;
         active_speed_ff     <= ACTIVE_SPEED_RESET;
         standstill_speed_ff <= STANDSTILL_SPEED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CYCLE_MS:         cycle_ms_ff         <= csr_data;
            CSR_VISUAL_MS:        visual_ms_ff        <= csr_data;
            CSR_AUDIBLE_MS:       audible_ms_ff       <= csr_data;
            CSR_ACTIVE_SPEED:     active_speed_ff     <= csr_data[SPEED_W-1:0];
            CSR_STANDSTILL_SPEED: standstill_speed_ff <= csr_data[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage boundaries. Each period is at most 16 bits, so the sum of all
   // three fits the 18-bit timer without wrapping.
   assign timer_sum = {1'b0, timer_ff} + (TIMER_W+1)'(in_dt_ff);
   assign timer_add = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
   assign bound1    = TIMER_W'(cycle_ms_ff);
   assign bound2    = bound1 + TIMER_W'(visual_ms_ff);
   assign bound3    = bound2 + TIMER_W'(audible_ms_ff);
   assign left1     = bound1 - timer_add;
   assign left2     = bound2 - timer_add;
   assign left3     = bound3 - timer_add;

   always_comb begin
      timer_in     = timer_ff;
      latch_in     = latch_ff;
      stage_in     = stage_ff;
      countdown_in = countdown_ff;
      if (in_kind_ff == REQ_TICK) begin
         if (latch_ff) begin
            // Latched penalty holds until a release at standstill.
            stage_in     = STAGE_PENALTY;
            countdown_in = '0;
         end else if (in_spd_ff < active_speed_ff) begin
            stage_in     = STAGE_INACTIVE;
            timer_in     = '0;
            countdown_in = cycle_ms_ff;
         end else begin
            timer_in = timer_add;
            if (timer_add < bound1) begin
               stage_in     = STAGE_ARMED;
               countdown_in = left1[MS_W-1:0];
            end else if (timer_add < bound2) begin
               stage_in     = STAGE_VISUAL;
               countdown_in = left2[MS_W-1:0];
            end else if (timer_add < bound3) begin
               stage_in     = STAGE_AUDIBLE;
               countdown_in = left3[MS_W-1:0];
            end else begin
               latch_in     = 1'b1;
               stage_in     = STAGE_PENALTY;
               countdown_in = '0;
            end
         end
      end else begin
         // An acknowledge leaves stage and countdown alone until the next tick;
         // in penalty it releases the latch and clears the timer only at standstill.
         if (stage_ff == STAGE_PENALTY) begin
            if (in_spd_ff < standstill_speed_ff) begin
               latch_in = 1'b0;
               timer_in = '0;
            end
         end else begin
            timer_in = '0;
         end
      end
      rsp_data_in = {
         (RSP_TDATA_W-STAGE_W-MS_W-1)'(0), latch_in, countdown_in, stage_in
      };
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff     <= TIMER_RESET;
         latch_ff     <= 1'b0;
         stage_ff     <= STAGE_INACTIVE;
         countdown_ff <= '0;
      end else if (advance) begin
         timer_ff     <= timer_in;
         latch_ff     <= latch_in;
         stage_ff     <= stage_in;
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### rtl/core/dvt_checker.sv
// ----------------------------------------------------------------------------
// dvt_checker
// Port-level assertions for the driver vigilance timer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "driver_vigilance_timer_macros.svh"

module dvt_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [dvt_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import dvt_pkg::*;

   logic [STAGE_W-1:0] rsp_stage;
   logic [MS_W-1:0]    rsp_countdown;
   logic               rsp_penalty;
   logic               rsp_running;

   assign rsp_stage     = rsp_tdata[STAGE_W-1:0];
   assign rsp_countdown = rsp_tdata[STAGE_W+MS_W-1:STAGE_W];
   assign rsp_penalty   = rsp_tdata[STAGE_W+MS_W];
   assign rsp_running   = (rsp_stage == STAGE_ARMED) || (rsp_stage == STAGE_VISUAL) ||
                          (rsp_stage == STAGE_AUDIBLE);

   `DVT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `DVT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `DVT_ASSERT_NOW(a_latch_in_penalty, clock, reset, rsp_tvalid && rsp_penalty, (rsp_stage == STAGE_PENALTY) && (rsp_countdown == '0))
   `DVT_ASSERT_NOW(a_running_time_left, clock, reset, rsp_tvalid && rsp_running, rsp_countdown != '0)

endmodule

bind driver_vigilance_timer dvt_checker u_dvt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
